// ----- sv/gb9_pkg.sv -----
// Shared types, constants and the kernel weight table of the Gaussian blur block.
`default_nettype none

package gb9_pkg;

    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;

    localparam int SIZE_W     = 7;
    localparam int CFG_ADDR_W = 1;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 6;
    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;

    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    localparam logic REQ_STORE  = 1'b0;
    localparam logic REQ_FILTER = 1'b1;

    localparam int TAPS      = 9;
    localparam int HALF_TAPS = 4;
    localparam int NUM_TAPS  = TAPS * TAPS;
    localparam int TAP_W     = $clog2(NUM_TAPS);
    localparam int WGT_W     = 10;
    localparam int PROD_W    = CH_W + WGT_W;
    localparam int ACC_W     = 26;
    localparam int FRAC_W    = 16;

    localparam logic [CH_W-1:0] ALPHA_VALUE = 8'd255;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic             req_type;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
    } gb9_item_t;

    typedef struct packed {
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
    } gb9_cfg_t;

    localparam logic [WGT_W-1:0] WEIGHT_Q16 [NUM_TAPS] = '{
        10'd736, 10'd763, 10'd782, 10'd794, 10'd798, 10'd794, 10'd782, 10'd763, 10'd736,
        10'd763, 10'd790, 10'd810, 10'd822, 10'd826, 10'd822, 10'd810, 10'd790, 10'd763,
        10'd782, 10'd810, 10'd830, 10'd843, 10'd847, 10'd843, 10'd830, 10'd810, 10'd782,
        10'd794, 10'd822, 10'd843, 10'd856, 10'd860, 10'd856, 10'd843, 10'd822, 10'd794,
        10'd798, 10'd826, 10'd847, 10'd860, 10'd864, 10'd860, 10'd847, 10'd826, 10'd798,
        10'd794, 10'd822, 10'd843, 10'd856, 10'd860, 10'd856, 10'd843, 10'd822, 10'd794,
        10'd782, 10'd810, 10'd830, 10'd843, 10'd847, 10'd843, 10'd830, 10'd810, 10'd782,
        10'd763, 10'd790, 10'd810, 10'd822, 10'd826, 10'd822, 10'd810, 10'd790, 10'd763,
        10'd736, 10'd763, 10'd782, 10'd794, 10'd798, 10'd794, 10'd782, 10'd763, 10'd736
    };

endpackage

`default_nettype wire

// ----- sv/gb9_front.sv -----
// Front end: size registers, item classification and drop of out-of-range stores.
`default_nettype none

module gb9_front #(
    parameter int MAX_WIDTH  = gb9_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = gb9_pkg::MAX_HEIGHT_DEF
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire                                s_req_type,
    input  wire  [gb9_pkg::ROW_W-1:0]          s_pixel_row,
    input  wire  [gb9_pkg::COL_W-1:0]          s_pixel_col,
    input  wire  [gb9_pkg::CH_W-1:0]           s_in_red,
    input  wire  [gb9_pkg::CH_W-1:0]           s_in_green,
    input  wire  [gb9_pkg::CH_W-1:0]           s_in_blue,
    input  wire                                cfg_wr_en,
    input  wire  [gb9_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire  [gb9_pkg::SIZE_W-1:0]         cfg_wdata,
    output logic                               q_valid,
    input  wire                                q_ready,
    output gb9_pkg::gb9_item_t                 q_item,
    output gb9_pkg::gb9_cfg_t                  cfg
);

    localparam int SIZE_MAX = (1 << gb9_pkg::SIZE_W) - 1;
    localparam logic [gb9_pkg::SIZE_W-1:0] MAX_W_SZ =
        (MAX_WIDTH > SIZE_MAX) ? gb9_pkg::SIZE_W'(SIZE_MAX) : gb9_pkg::SIZE_W'(MAX_WIDTH);
    localparam logic [gb9_pkg::SIZE_W-1:0] MAX_H_SZ =
        (MAX_HEIGHT > SIZE_MAX) ? gb9_pkg::SIZE_W'(SIZE_MAX) : gb9_pkg::SIZE_W'(MAX_HEIGHT);

    function automatic logic [gb9_pkg::SIZE_W-1:0] clamp_size(
        input logic [gb9_pkg::SIZE_W-1:0] v,
        input logic [gb9_pkg::SIZE_W-1:0] max_v
    );
        logic [gb9_pkg::SIZE_W-1:0] r;
        if (v == '0) begin
            r = gb9_pkg::SIZE_W'(1);
        end else if (v > max_v) begin
            r = max_v;
        end else begin
            r = v;
        end
        return r;
    endfunction

    logic [gb9_pkg::SIZE_W-1:0] width_reg, width_next;
    logic [gb9_pkg::SIZE_W-1:0] height_reg, height_next;
    logic in_range;
    logic keep;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                gb9_pkg::REG_IMAGE_WIDTH:  width_next  = clamp_size(cfg_wdata, MAX_W_SZ);
                gb9_pkg::REG_IMAGE_HEIGHT: height_next = clamp_size(cfg_wdata, MAX_H_SZ);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= clamp_size(gb9_pkg::SIZE_RESET, MAX_W_SZ);
            height_reg <= clamp_size(gb9_pkg::SIZE_RESET, MAX_H_SZ);
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // drop stores that fall outside the frame store
    assign in_range = (32'(s_pixel_row) < MAX_HEIGHT) && (32'(s_pixel_col) < MAX_WIDTH);
    assign keep     = (s_req_type == gb9_pkg::REQ_FILTER) || in_range;

    assign q_valid = s_valid && keep;
    assign s_ready = q_ready || !keep;

    assign q_item.req_type = s_req_type;
    assign q_item.row      = s_pixel_row;
    assign q_item.col      = s_pixel_col;
    assign q_item.red      = s_in_red;
    assign q_item.green    = s_in_green;
    assign q_item.blue     = s_in_blue;

    assign cfg.width  = width_reg;
    assign cfg.height = height_reg;

endmodule

`default_nettype wire

// ----- sv/gb9_fifo.sv -----
// Short item queue between the front end and the filter engine.
`default_nettype none

module gb9_fifo (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 push_valid,
    output logic                push_ready,
    input  gb9_pkg::gb9_item_t  push_item,
    output logic                pop_valid,
    input  wire                 pop_ready,
    output gb9_pkg::gb9_item_t  pop_item
);

    localparam int PTR_W = (gb9_pkg::QUEUE_DEPTH > 1) ? $clog2(gb9_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(gb9_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(gb9_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(gb9_pkg::QUEUE_DEPTH);

    gb9_pkg::gb9_item_t entry_reg [gb9_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic do_push;
    logic do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ----- sv/gb9_back.sv -----
// Filter engine: frame store, wrap setup sequencer, tap loop and output register.
`default_nettype none

module gb9_back #(
    parameter int MAX_WIDTH  = gb9_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = gb9_pkg::MAX_HEIGHT_DEF
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  gb9_pkg::gb9_cfg_t             cfg,
    input  wire                           q_valid,
    output logic                          q_ready,
    input  gb9_pkg::gb9_item_t            q_item,
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic [gb9_pkg::ROW_W-1:0]     m_out_row,
    output logic [gb9_pkg::COL_W-1:0]     m_out_col,
    output logic [gb9_pkg::CH_W-1:0]      m_out_red,
    output logic [gb9_pkg::CH_W-1:0]      m_out_green,
    output logic [gb9_pkg::CH_W-1:0]      m_out_blue,
    output logic [gb9_pkg::CH_W-1:0]      m_out_alpha
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = $clog2(DEPTH);
    localparam int SW     = gb9_pkg::SIZE_W;
    localparam int BIT_W  = $clog2(gb9_pkg::ROW_W);
    localparam int STEP_W = $clog2(gb9_pkg::HALF_TAPS);
    localparam int N_W    = $clog2(gb9_pkg::TAPS);
    localparam int TAP_W  = gb9_pkg::TAP_W;
    localparam int PW     = gb9_pkg::PROD_W;
    localparam int AWC    = gb9_pkg::ACC_W;
    localparam int CW     = gb9_pkg::CH_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_BACK  = 3'd2;
    localparam logic [2:0] ST_TAP   = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;

    function automatic logic [SW-1:0] div_step(
        input logic [SW-1:0] rem,
        input logic          b,
        input logic [SW-1:0] size
    );
        logic [SW:0] t;
        t = {rem, b};
        if (t >= {1'b0, size}) begin
            t = t - {1'b0, size};
        end
        return t[SW-1:0];
    endfunction

    function automatic logic [SW-1:0] dec_wrap(input logic [SW-1:0] v, input logic [SW-1:0] size);
        return (v == '0) ? size - SW'(1) : v - SW'(1);
    endfunction

    function automatic logic [SW-1:0] inc_wrap(input logic [SW-1:0] v, input logic [SW-1:0] size);
        return (v == size - SW'(1)) ? '0 : v + SW'(1);
    endfunction

    function automatic logic [CW-1:0] sat8(input logic [AWC-1:0] acc);
        logic [AWC-gb9_pkg::FRAC_W-1:0] hi;
        hi = acc[AWC-1:gb9_pkg::FRAC_W];
        return (hi > (AWC-gb9_pkg::FRAC_W)'(255)) ? CW'(255) : hi[CW-1:0];
    endfunction

    logic [gb9_pkg::PIX_W-1:0] frame_mem [DEPTH];
    logic [gb9_pkg::PIX_W-1:0] rd_data_reg;

    logic [2:0]               state_reg, state_next;
    logic [gb9_pkg::ROW_W-1:0] row_reg, row_next;
    logic [gb9_pkg::COL_W-1:0] col_reg, col_next;
    logic [SW-1:0]            rr_reg, rr_next;
    logic [SW-1:0]            cc_reg, cc_next;
    logic [SW-1:0]            cstart_reg, cstart_next;
    logic [BIT_W-1:0]         bit_reg, bit_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic [N_W-1:0]           n_reg, n_next;
    logic [TAP_W-1:0]         tap_reg, tap_next;
    logic                     rd_v_reg, rd_v_next;
    logic [gb9_pkg::WGT_W-1:0] wgt_reg, wgt_next;
    logic                     prod_v_reg, prod_v_next;
    logic [PW-1:0]            prod_r_reg, prod_g_reg, prod_b_reg;
    logic [PW-1:0]            prod_r_next, prod_g_next, prod_b_next;
    logic [AWC-1:0]           acc_r_reg, acc_g_reg, acc_b_reg;
    logic [AWC-1:0]           acc_r_next, acc_g_next, acc_b_next;
    logic                     m_valid_reg, m_valid_next;
    logic [gb9_pkg::ROW_W-1:0] out_row_reg, out_row_next;
    logic [gb9_pkg::COL_W-1:0] out_col_reg, out_col_next;
    logic [CW-1:0]            out_red_reg, out_red_next;
    logic [CW-1:0]            out_green_reg, out_green_next;
    logic [CW-1:0]            out_blue_reg, out_blue_next;

    logic                     mem_we;
    logic [AW-1:0]            wr_addr;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic [SW-1:0]            rr_dec;
    logic [SW-1:0]            cc_dec;
    logic                     load_out;

    assign q_ready = (state_reg == ST_IDLE);
    assign wr_addr = AW'(32'(q_item.row) * MAX_WIDTH + 32'(q_item.col));
    assign rd_addr = AW'(32'(rr_reg) * MAX_WIDTH + 32'(cc_reg));
    assign rr_dec  = dec_wrap(rr_reg, cfg.height);
    assign cc_dec  = dec_wrap(cc_reg, cfg.width);

    always_comb begin
        state_next  = state_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        rr_next     = rr_reg;
        cc_next     = cc_reg;
        cstart_next = cstart_reg;
        bit_next    = bit_reg;
        step_next   = step_reg;
        n_next      = n_reg;
        tap_next    = tap_reg;
        acc_r_next  = acc_r_reg;
        acc_g_next  = acc_g_reg;
        acc_b_next  = acc_b_reg;
        mem_we      = 1'b0;
        rd_en       = 1'b0;
        load_out    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    if (q_item.req_type == gb9_pkg::REQ_STORE) begin
                        mem_we = 1'b1;
                    end else begin
                        row_next   = q_item.row;
                        col_next   = q_item.col;
                        rr_next    = '0;
                        cc_next    = '0;
                        bit_next   = BIT_W'(gb9_pkg::ROW_W - 1);
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                // reduce the position modulo the image size, one bit a cycle
                rr_next = div_step(rr_reg, row_reg[bit_reg], cfg.height);
                cc_next = div_step(cc_reg, col_reg[bit_reg], cfg.width);
                if (bit_reg == '0) begin
                    step_next  = STEP_W'(gb9_pkg::HALF_TAPS - 1);
                    state_next = ST_BACK;
                end else begin
                    bit_next = bit_reg - BIT_W'(1);
                end
            end
            ST_BACK: begin
                // step back to the top left tap of the window
                rr_next = rr_dec;
                cc_next = cc_dec;
                if (step_reg == '0) begin
                    cstart_next = cc_dec;
                    n_next      = '0;
                    tap_next    = '0;
                    acc_r_next  = '0;
                    acc_g_next  = '0;
                    acc_b_next  = '0;
                    state_next  = ST_TAP;
                end else begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            ST_TAP: begin
                rd_en = 1'b1;
                if (n_reg == N_W'(gb9_pkg::TAPS - 1)) begin
                    n_next  = '0;
                    cc_next = cstart_reg;
                    rr_next = inc_wrap(rr_reg, cfg.height);
                end else begin
                    n_next  = n_reg + N_W'(1);
                    cc_next = inc_wrap(cc_reg, cfg.width);
                end
                tap_next = tap_reg + TAP_W'(1);
                if (tap_reg == TAP_W'(gb9_pkg::NUM_TAPS - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!rd_v_reg && !prod_v_reg && (!m_valid_reg || m_ready)) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (prod_v_reg) begin
            acc_r_next = acc_r_reg + AWC'(prod_r_reg);
            acc_g_next = acc_g_reg + AWC'(prod_g_reg);
            acc_b_next = acc_b_reg + AWC'(prod_b_reg);
        end
    end

    assign rd_v_next   = rd_en;
    assign wgt_next    = gb9_pkg::WEIGHT_Q16[tap_reg];
    assign prod_v_next = rd_v_reg;
    assign prod_r_next = PW'(rd_data_reg[3*CW-1:2*CW]) * PW'(wgt_reg);
    assign prod_g_next = PW'(rd_data_reg[2*CW-1:CW]) * PW'(wgt_reg);
    assign prod_b_next = PW'(rd_data_reg[CW-1:0]) * PW'(wgt_reg);

    always_comb begin
        m_valid_next   = m_valid_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_red_next   = out_red_reg;
        out_green_next = out_green_reg;
        out_blue_next  = out_blue_reg;
        if (load_out) begin
            m_valid_next   = 1'b1;
            out_row_next   = row_reg;
            out_col_next   = col_reg;
            out_red_next   = sat8(acc_r_reg);
            out_green_next = sat8(acc_g_reg);
            out_blue_next  = sat8(acc_b_reg);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            frame_mem[wr_addr] <= {q_item.red, q_item.green, q_item.blue};
        end
        if (rd_en) begin
            rd_data_reg <= frame_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rd_v_reg    <= 1'b0;
            prod_v_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_v_reg    <= rd_v_next;
            prod_v_reg  <= prod_v_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        row_reg       <= row_next;
        col_reg       <= col_next;
        rr_reg        <= rr_next;
        cc_reg        <= cc_next;
        cstart_reg    <= cstart_next;
        bit_reg       <= bit_next;
        step_reg      <= step_next;
        n_reg         <= n_next;
        tap_reg       <= tap_next;
        wgt_reg       <= wgt_next;
        prod_r_reg    <= prod_r_next;
        prod_g_reg    <= prod_g_next;
        prod_b_reg    <= prod_b_next;
        acc_r_reg     <= acc_r_next;
        acc_g_reg     <= acc_g_next;
        acc_b_reg     <= acc_b_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_red_reg   <= out_red_next;
        out_green_reg <= out_green_next;
        out_blue_reg  <= out_blue_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_out_row   = out_row_reg;
    assign m_out_col   = out_col_reg;
    assign m_out_red   = out_red_reg;
    assign m_out_green = out_green_reg;
    assign m_out_blue  = out_blue_reg;
    assign m_out_alpha = gb9_pkg::ALPHA_VALUE;

endmodule

`default_nettype wire

// ----- sv/gaussian_blur_9x9_rgb.sv -----
// Top level of the 9x9 Gaussian blur frame store: front end, item queue and filter engine.
// Store item: one per cycle while the engine is idle, written to the frame store in the cycle after accept.
// Filter item: with an idle engine the result passes through the queue, a modulo setup over the
//   6 position bits, 4 wrap steps, 81 taps at one frame store read each, and the drain.
// Filter items: the engine takes no new item until the last result is loaded; the tap loop uses
//   the single frame store read port once per tap. A stalled result holds the engine. Reset: queue
//   and engine empty, sizes at 64 (or the maximum); frame store is not cleared.
`default_nettype none

module gaussian_blur_9x9_rgb #(
    parameter int MAX_WIDTH  = gb9_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = gb9_pkg::MAX_HEIGHT_DEF
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_valid,
    output logic                            s_ready,
    input  wire                             s_req_type,
    input  wire  [gb9_pkg::ROW_W-1:0]       s_pixel_row,
    input  wire  [gb9_pkg::COL_W-1:0]       s_pixel_col,
    input  wire  [gb9_pkg::CH_W-1:0]        s_in_red,
    input  wire  [gb9_pkg::CH_W-1:0]        s_in_green,
    input  wire  [gb9_pkg::CH_W-1:0]        s_in_blue,
    output logic                            m_valid,
    input  wire                             m_ready,
    output logic [gb9_pkg::ROW_W-1:0]       m_out_row,
    output logic [gb9_pkg::COL_W-1:0]       m_out_col,
    output logic [gb9_pkg::CH_W-1:0]        m_out_red,
    output logic [gb9_pkg::CH_W-1:0]        m_out_green,
    output logic [gb9_pkg::CH_W-1:0]        m_out_blue,
    output logic [gb9_pkg::CH_W-1:0]        m_out_alpha,
    input  wire                             cfg_wr_en,
    input  wire  [gb9_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire  [gb9_pkg::SIZE_W-1:0]      cfg_wdata
);

    logic               push_valid;
    logic               push_ready;
    gb9_pkg::gb9_item_t push_item;
    logic               pop_valid;
    logic               pop_ready;
    gb9_pkg::gb9_item_t pop_item;
    gb9_pkg::gb9_cfg_t  cfg;

    gb9_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_pixel_row (s_pixel_row),
        .s_pixel_col (s_pixel_col),
        .s_in_red    (s_in_red),
        .s_in_green  (s_in_green),
        .s_in_blue   (s_in_blue),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .q_valid     (push_valid),
        .q_ready     (push_ready),
        .q_item      (push_item),
        .cfg         (cfg)
    );

    gb9_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    gb9_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .q_valid     (pop_valid),
        .q_ready     (pop_ready),
        .q_item      (pop_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_row   (m_out_row),
        .m_out_col   (m_out_col),
        .m_out_red   (m_out_red),
        .m_out_green (m_out_green),
        .m_out_blue  (m_out_blue),
        .m_out_alpha (m_out_alpha)
    );

endmodule

`default_nettype wire

// ----- sv/gb9_checker.sv -----
// Port-level assertions for the Gaussian blur block and the bind that attaches them.
`default_nettype none

module gb9_checker (
    input wire                             aclk,
    input wire                             aresetn,
    input wire                             s_valid,
    input wire                             s_ready,
    input wire                             s_req_type,
    input wire                             m_valid,
    input wire                             m_ready,
    input wire [gb9_pkg::ROW_W-1:0]        m_out_row,
    input wire [gb9_pkg::COL_W-1:0]        m_out_col,
    input wire [gb9_pkg::CH_W-1:0]         m_out_red,
    input wire [gb9_pkg::CH_W-1:0]         m_out_green,
    input wire [gb9_pkg::CH_W-1:0]         m_out_blue,
    input wire [gb9_pkg::CH_W-1:0]         m_out_alpha
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_alpha_opaque: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_out_alpha == gb9_pkg::ALPHA_VALUE))
        else $error("alpha not opaque");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_out_row) && $stable(m_out_col)
            && $stable(m_out_red) && $stable(m_out_green) && $stable(m_out_blue)))
        else $error("stalled result changed");

    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_valid && s_ready && (s_req_type == gb9_pkg::REQ_FILTER)))
        else $error("result appeared one cycle after filter accept");

endmodule

bind gaussian_blur_9x9_rgb gb9_checker u_gb9_checker (.*);

`default_nettype wire

// ----- sim/tb_gaussian_blur_9x9_rgb.sv -----
// Self-checking testbench of the 9x9 Gaussian blur frame store, with its own blur predictor.
module tb_gaussian_blur_9x9_rgb;
    import gb9_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 120;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int FRAME_COLS    = MAX_WIDTH_DEF;
    localparam int FRAME_ROWS    = MAX_HEIGHT_DEF;
    localparam int KERN_TAPS     = 9;
    localparam int KERN_HALF     = 4;

    typedef struct {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [CH_W-1:0]  alpha;
    } blur_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_req_type;
    logic [ROW_W-1:0]      s_pixel_row;
    logic [COL_W-1:0]      s_pixel_col;
    logic [CH_W-1:0]       s_in_red;
    logic [CH_W-1:0]       s_in_green;
    logic [CH_W-1:0]       s_in_blue;
    logic                  m_valid;
    logic                  m_ready;
    logic [ROW_W-1:0]      m_out_row;
    logic [COL_W-1:0]      m_out_col;
    logic [CH_W-1:0]       m_out_red;
    logic [CH_W-1:0]       m_out_green;
    logic [CH_W-1:0]       m_out_blue;
    logic [CH_W-1:0]       m_out_alpha;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [SIZE_W-1:0]     cfg_wdata;

    logic [PIX_W-1:0] pix_model [FRAME_COLS*FRAME_ROWS];
    bit               pix_written [FRAME_COLS*FRAME_ROWS];
    int unsigned      img_w;
    int unsigned      img_h;
    blur_result_t     blur_q [$];
    int               err_count;
    int               items_sent;
    int unsigned      tx_max_gap;
    int unsigned      rx_max_gap;

    gaussian_blur_9x9_rgb i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_pixel_row (s_pixel_row),
        .s_pixel_col (s_pixel_col),
        .s_in_red    (s_in_red),
        .s_in_green  (s_in_green),
        .s_in_blue   (s_in_blue),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_row   (m_out_row),
        .m_out_col   (m_out_col),
        .m_out_red   (m_out_red),
        .m_out_green (m_out_green),
        .m_out_blue  (m_out_blue),
        .m_out_alpha (m_out_alpha),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata)
    );

    always #(CLK_PERIOD/2) aclk = ~aclk;

    function automatic int unsigned size_from_reg(logic [SIZE_W-1:0] v, int unsigned limit);
        if (v == 0) return 1;
        if (32'(v) > limit) return limit;
        return 32'(v);
    endfunction

    // weight by distance from the kernel center along each axis
    function automatic int unsigned tap_weight(int unsigned dr, int unsigned dc);
        int unsigned ring [5];
        case (dr)
            0: ring = '{864, 860, 847, 826, 798};
            1: ring = '{860, 856, 843, 822, 794};
            2: ring = '{847, 843, 830, 810, 782};
            3: ring = '{826, 822, 810, 790, 763};
            default: ring = '{798, 794, 782, 763, 736};
        endcase
        return ring[dc];
    endfunction

    function automatic int unsigned wrap_row(logic [ROW_W-1:0] row, int m);
        return (int'(row) + m + KERN_HALF * img_h - KERN_HALF) % img_h;
    endfunction

    function automatic int unsigned wrap_col(logic [COL_W-1:0] col, int n);
        return (int'(col) + n + KERN_HALF * img_w - KERN_HALF) % img_w;
    endfunction

    function automatic logic [CH_W-1:0] sat_chan(int unsigned acc);
        int unsigned v;
        v = acc >> 16;
        return (v > 255) ? 8'd255 : v[CH_W-1:0];
    endfunction

    function automatic blur_result_t blur_at(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
        blur_result_t     res;
        int unsigned      acc_r, acc_g, acc_b, wq, dr, dc;
        logic [PIX_W-1:0] px;
        acc_r = 0;
        acc_g = 0;
        acc_b = 0;
        for (int m = 0; m < KERN_TAPS; m++) begin
            dr = (m < KERN_HALF) ? KERN_HALF - m : m - KERN_HALF;
            for (int n = 0; n < KERN_TAPS; n++) begin
                dc = (n < KERN_HALF) ? KERN_HALF - n : n - KERN_HALF;
                wq = tap_weight(dr, dc);
                px = pix_model[wrap_row(row, m) * FRAME_COLS + wrap_col(col, n)];
                acc_r += 32'(px[23:16]) * wq;
                acc_g += 32'(px[15:8]) * wq;
                acc_b += 32'(px[7:0]) * wq;
            end
        end
        res.row   = row;
        res.col   = col;
        res.red   = sat_chan(acc_r);
        res.green = sat_chan(acc_g);
        res.blue  = sat_chan(acc_b);
        res.alpha = 8'd255;
        return res;
    endfunction

    function automatic logic [CH_W-1:0] rand_chan();
        case ($urandom_range(3, 0))
            0: return 8'd0;
            1: return 8'd255;
            default: return CH_W'($urandom);
        endcase
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            err_count++;
        end
    endfunction

    task automatic send_item(logic kind, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                             logic [CH_W-1:0] red, logic [CH_W-1:0] green,
                             logic [CH_W-1:0] blue);
        int unsigned gap;
        int unsigned idx;
        gap = $urandom_range(tx_max_gap, 0);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_req_type  <= kind;
        s_pixel_row <= row;
        s_pixel_col <= col;
        s_in_red    <= red;
        s_in_green  <= green;
        s_in_blue   <= blue;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        items_sent++;
        if (kind == REQ_STORE) begin
            idx = int'(row) * FRAME_COLS + int'(col);
            pix_model[idx]   = {red, green, blue};
            pix_written[idx] = 1'b1;
        end else begin
            blur_q.push_back(blur_at(row, col));
        end
    endtask

    // write every unwritten pixel that the window around (row, col) reads
    task automatic fill_window(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
        int unsigned rr, cc;
        for (int m = 0; m < KERN_TAPS; m++) begin
            for (int n = 0; n < KERN_TAPS; n++) begin
                rr = wrap_row(row, m);
                cc = wrap_col(col, n);
                if (!pix_written[rr * FRAME_COLS + cc])
                    send_item(REQ_STORE, rr[ROW_W-1:0], cc[COL_W-1:0],
                              rand_chan(), rand_chan(), rand_chan());
            end
        end
    endtask

    task automatic filter_at(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
        fill_window(row, col);
        send_item(REQ_FILTER, row, col, rand_chan(), rand_chan(), rand_chan());
    endtask

    task automatic hold_sender();
        s_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic pause_until_drained();
        hold_sender();
        while (blur_q.size() != 0) @(negedge aclk);
    endtask

    task automatic settle();
        pause_until_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_image_size(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_IMAGE_WIDTH;
        cfg_wdata <= w;
        @(negedge aclk);
        cfg_addr  <= REG_IMAGE_HEIGHT;
        cfg_wdata <= h;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        img_w = size_from_reg(w, FRAME_COLS);
        img_h = size_from_reg(h, FRAME_ROWS);
        @(negedge aclk);
    endtask

    task automatic run_random(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h, int count,
                              int unsigned tx_gap, int unsigned rx_gap, bit clustered);
        int               stop_at;
        logic [ROW_W-1:0] anchor_r, row;
        logic [COL_W-1:0] anchor_c, col;
        set_image_size(w, h);
        tx_max_gap = tx_gap;
        rx_max_gap = rx_gap;
        anchor_r   = ROW_W'($urandom);
        anchor_c   = COL_W'($urandom);
        stop_at    = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(99, 0) < 35) begin
                row = ROW_W'(clustered ? 32'(anchor_r) + $urandom_range(3, 0) : $urandom);
                col = COL_W'(clustered ? 32'(anchor_c) + $urandom_range(3, 0) : $urandom);
                filter_at(row, col);
                if ($urandom_range(19, 0) == 0)
                    pause_until_drained();
            end else begin
                send_item(REQ_STORE, ROW_W'($urandom), COL_W'($urandom),
                          rand_chan(), rand_chan(), rand_chan());
            end
        end
    endtask

    task automatic test_reset_size();
        tx_max_gap = 9;
        rx_max_gap = 9;
        filter_at(6'd0, 6'd0);
        filter_at(6'd63, 6'd63);
        filter_at(6'd1, 6'd62);
    endtask

    task automatic test_single_pixel();
        set_image_size(7'd0, 7'd0);
        tx_max_gap = 0;
        rx_max_gap = 0;
        send_item(REQ_STORE, 6'd0, 6'd0, 8'hff, 8'hff, 8'hff);
        send_item(REQ_FILTER, 6'd0, 6'd0, 8'h00, 8'h00, 8'h00);
        send_item(REQ_FILTER, 6'd63, 6'd63, 8'hff, 8'hff, 8'hff);
        send_item(REQ_STORE, 6'd0, 6'd0, 8'h00, 8'h00, 8'h00);
        send_item(REQ_FILTER, 6'd42, 6'd21, 8'ha5, 8'h5a, 8'h3c);
        pause_until_drained();
        send_item(REQ_STORE, 6'd0, 6'd0, 8'hff, 8'h00, 8'h5a);
        send_item(REQ_FILTER, 6'd0, 6'd0, 8'h00, 8'h00, 8'h00);
        send_item(REQ_STORE, 6'd63, 6'd63, 8'h12, 8'h34, 8'h56);
        send_item(REQ_STORE, 6'd0, 6'd0, 8'h00, 8'hff, 8'h01);
        send_item(REQ_FILTER, 6'd21, 6'd42, 8'h00, 8'h00, 8'h00);
    endtask

    task automatic test_small_image();
        run_random(7'd5, 7'd5, 90, 9, 9, 1'b0);
    endtask

    task automatic test_strips();
        run_random(7'd64, 7'd5, 70, 0, 9, 1'b0);
        run_random(7'd5, 7'd64, 70, 9, 0, 1'b0);
    endtask

    task automatic test_random_sizes();
        run_random(SIZE_W'($urandom_range(20, 5)), SIZE_W'($urandom_range(20, 5)),
                   70, 9, 0, 1'b0);
        run_random(SIZE_W'($urandom_range(20, 5)), SIZE_W'($urandom_range(20, 5)),
                   70, 0, 9, 1'b0);
        run_random(SIZE_W'($urandom_range(20, 5)), SIZE_W'($urandom_range(20, 5)),
                   70, 9, 9, 1'b0);
    endtask

    task automatic test_register_clamp();
        run_random(7'd127, 7'd100, 70, 9, 9, 1'b1);
        run_random(7'd65, 7'd0, 50, 9, 9, 1'b0);
    endtask

    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin : ready_gen
            int unsigned gap;
            gap = $urandom_range(rx_max_gap, 0);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin : result_check
        blur_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (blur_q.size() == 0) begin
                $display("%0t: result row %0d col %0d expected none, got one",
                         $time, m_out_row, m_out_col);
                err_count++;
            end else begin
                want = blur_q.pop_front();
                check_field("out_row", 32'(want.row), 32'(m_out_row));
                check_field("out_col", 32'(want.col), 32'(m_out_col));
                check_field("out_red", 32'(want.red), 32'(m_out_red));
                check_field("out_green", 32'(want.green), 32'(m_out_green));
                check_field("out_blue", 32'(want.blue), 32'(m_out_blue));
                check_field("out_alpha", 32'(want.alpha), 32'(m_out_alpha));
            end
        end
    end

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_req_type  = REQ_STORE;
        s_pixel_row = '0;
        s_pixel_col = '0;
        s_in_red    = '0;
        s_in_green  = '0;
        s_in_blue   = '0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = REG_IMAGE_WIDTH;
        cfg_wdata   = '0;
        err_count   = 0;
        items_sent  = 0;
        tx_max_gap  = 0;
        rx_max_gap  = 0;
        img_w       = FRAME_COLS;
        img_h       = FRAME_ROWS;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_reset_size();
        test_single_pixel();
        test_small_image();
        test_strips();
        test_random_sizes();
        test_register_clamp();
        settle();
        if (err_count == 0)
            $display("tb_gaussian_blur_9x9_rgb: done, clean");
        else
            $display("tb_gaussian_blur_9x9_rgb: done, errors");
        $finish;
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("%0t: timeout", $time);
        $display("tb_gaussian_blur_9x9_rgb: done, errors");
        $finish;
    end

endmodule
